// File: design/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types, codes and defaults of the sorted string set engine.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int KEY_BYTES_DEF = 20;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DELETED   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;
  localparam logic [2:0] ST_BYTE      = 3'd5;
  localparam logic [2:0] ST_BAD_INDEX = 3'd6;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] key_char;
    logic       key_last;
    logic [3:0] entry_index;
  } req_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_char;
    logic       out_last;
    logic [4:0] entry_count;
  } rsp_word_t;

  typedef struct packed {
    logic       in_take;
    logic       key_clr;
    logic       p_clr;
    logic       p_inc;
    logic       set_eq;
    logic       i_load_p;
    logic       i_load_cnt;
    logic       i_step;
    logic       j_clr;
    logic       j_inc;
    logic       lrd;
    logic       lrd_src;
    logic       lwr_mv;
    logic       lwr_key;
    logic       wrd;
    logic       wrd_src;
    logic       krd;
    logic       wwr_mv;
    logic       wwr_key;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       out_load;
    logic [2:0] out_code;
    logic       out_byte;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       last;
    logic       ovf_now;
    logic       full;
    logic       idx_bad;
    logic       j_lt_n;
    logic       key_eq_w;
    logic       key_lt_w;
    logic       byte_ne;
    logic       key_byte_lt;
    logic       p_lt_cnt;
    logic       i_gt_p;
    logic       i_nxt_lt_cnt;
    logic       j_lt_wl;
    logic       j_lt_klen;
    logic       j_last;
    logic       del;
    logic       eq_found;
    logic       out_busy;
  } sts_t;

endpackage

// File: design/sss_ctrl.sv
// ----------------------------------------------------------------------------
// sss_ctrl
// Sequencer for key collection, sorted search, entry moves and reads.
// ----------------------------------------------------------------------------
module sss_ctrl import sss_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [19:0] {
    S_IDLE      = 20'h00001,
    S_RES       = 20'h00002,
    S_RD_LEN    = 20'h00004,
    S_RD_CHK    = 20'h00008,
    S_RD_BYTE   = 20'h00010,
    S_RD_OUT    = 20'h00020,
    S_RD_WAIT   = 20'h00040,
    S_SRCH_CHK  = 20'h00080,
    S_CMP_LEN   = 20'h00100,
    S_CMP_BYTE  = 20'h00200,
    S_CMP_CHK   = 20'h00400,
    S_OP        = 20'h00800,
    S_SHIFT_CHK = 20'h01000,
    S_MV_LEN    = 20'h02000,
    S_MV_LENW   = 20'h04000,
    S_MV_RD     = 20'h08000,
    S_MV_WR     = 20'h10000,
    S_KW_LEN    = 20'h20000,
    S_KW_RD     = 20'h40000,
    S_KW_WR     = 20'h80000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_take = 1'b1;
          case (sts.req)
            REQ_READ: begin
              if (sts.idx_bad) begin
                cmd.out_load = 1'b1;
                cmd.out_code = ST_BAD_INDEX;
                state_next = S_RES;
              end else begin
                state_next = S_RD_LEN;
              end
            end
            REQ_INSERT, REQ_DELETE: begin
              if (sts.last) begin
                if (sts.ovf_now) begin
                  cmd.out_load = 1'b1;
                  cmd.out_code = ST_TOO_LONG;
                  cmd.key_clr = 1'b1;
                  state_next = S_RES;
                end else if (sts.req == REQ_INSERT && sts.full) begin
                  cmd.out_load = 1'b1;
                  cmd.out_code = ST_FULL;
                  cmd.key_clr = 1'b1;
                  state_next = S_RES;
                end else begin
                  cmd.p_clr = 1'b1;
                  state_next = S_SRCH_CHK;
                end
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RES: begin
        if (!sts.out_busy) state_next = S_IDLE;
      end
      S_RD_LEN: begin
        cmd.lrd = 1'b1;
        cmd.j_clr = 1'b1;
        state_next = S_RD_CHK;
      end
      S_RD_CHK: begin
        if (!sts.j_lt_wl) begin
          cmd.out_load = 1'b1;
          cmd.out_code = ST_BYTE;
          state_next = S_RES;
        end else begin
          state_next = S_RD_BYTE;
        end
      end
      S_RD_BYTE: begin
        cmd.wrd = 1'b1;
        state_next = S_RD_OUT;
      end
      S_RD_OUT: begin
        cmd.out_load = 1'b1;
        cmd.out_code = ST_BYTE;
        cmd.out_byte = 1'b1;
        state_next = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        if (!sts.out_busy) begin
          if (sts.j_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.j_inc = 1'b1;
            state_next = S_RD_BYTE;
          end
        end
      end
      S_SRCH_CHK: begin
        state_next = sts.p_lt_cnt ? S_CMP_LEN : S_OP;
      end
      S_CMP_LEN: begin
        cmd.lrd = 1'b1;
        cmd.j_clr = 1'b1;
        state_next = S_CMP_BYTE;
      end
      S_CMP_BYTE: begin
        if (sts.j_lt_n) begin
          cmd.wrd = 1'b1;
          cmd.krd = 1'b1;
          state_next = S_CMP_CHK;
        end else if (sts.key_eq_w) begin
          cmd.set_eq = 1'b1;
          state_next = S_OP;
        end else if (sts.key_lt_w) begin
          state_next = S_OP;
        end else begin
          cmd.p_inc = 1'b1;
          state_next = S_SRCH_CHK;
        end
      end
      S_CMP_CHK: begin
        if (!sts.byte_ne) begin
          cmd.j_inc = 1'b1;
          state_next = S_CMP_BYTE;
        end else if (sts.key_byte_lt) begin
          state_next = S_OP;
        end else begin
          cmd.p_inc = 1'b1;
          state_next = S_SRCH_CHK;
        end
      end
      S_OP: begin
        if (!sts.del) begin
          cmd.i_load_cnt = 1'b1;
          state_next = S_SHIFT_CHK;
        end else if (sts.p_lt_cnt && sts.eq_found) begin
          cmd.i_load_p = 1'b1;
          state_next = S_SHIFT_CHK;
        end else begin
          cmd.out_load = 1'b1;
          cmd.out_code = ST_NOT_FOUND;
          cmd.key_clr = 1'b1;
          state_next = S_RES;
        end
      end
      S_SHIFT_CHK: begin
        if (sts.del) begin
          if (sts.i_nxt_lt_cnt) begin
            state_next = S_MV_LEN;
          end else begin
            cmd.cnt_dec = 1'b1;
            cmd.out_load = 1'b1;
            cmd.out_code = ST_DELETED;
            cmd.key_clr = 1'b1;
            state_next = S_RES;
          end
        end else begin
          state_next = sts.i_gt_p ? S_MV_LEN : S_KW_LEN;
        end
      end
      S_MV_LEN: begin
        cmd.lrd = 1'b1;
        cmd.lrd_src = 1'b1;
        state_next = S_MV_LENW;
      end
      S_MV_LENW: begin
        cmd.lwr_mv = 1'b1;
        cmd.j_clr = 1'b1;
        state_next = S_MV_RD;
      end
      S_MV_RD: begin
        if (sts.j_lt_wl) begin
          cmd.wrd = 1'b1;
          cmd.wrd_src = 1'b1;
          state_next = S_MV_WR;
        end else begin
          cmd.i_step = 1'b1;
          state_next = S_SHIFT_CHK;
        end
      end
      S_MV_WR: begin
        cmd.wwr_mv = 1'b1;
        cmd.j_inc = 1'b1;
        state_next = S_MV_RD;
      end
      S_KW_LEN: begin
        cmd.lwr_key = 1'b1;
        cmd.j_clr = 1'b1;
        state_next = S_KW_RD;
      end
      S_KW_RD: begin
        if (sts.j_lt_klen) begin
          cmd.krd = 1'b1;
          state_next = S_KW_WR;
        end else begin
          cmd.cnt_inc = 1'b1;
          cmd.out_load = 1'b1;
          cmd.out_code = ST_INSERTED;
          cmd.key_clr = 1'b1;
          state_next = S_RES;
        end
      end
      S_KW_WR: begin
        cmd.wwr_key = 1'b1;
        cmd.j_inc = 1'b1;
        state_next = S_KW_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: design/sss_dpath.sv
// ----------------------------------------------------------------------------
// sss_dpath
// Key buffer, word and length memories, counters and the result register.
// ----------------------------------------------------------------------------
module sss_dpath import sss_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  req_word_t req,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_word_t rsp
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PW  = $clog2(CAPACITY);
  localparam int JW  = $clog2(KEY_BYTES + 1);
  localparam int KIW = $clog2(KEY_BYTES);
  localparam int AW  = $clog2(CAPACITY * KEY_BYTES);
  localparam int WD  = CAPACITY * KEY_BYTES;

  logic [7:0]    kbuf [KEY_BYTES];
  logic [7:0]    wmem [WD];
  logic [JW-1:0] lmem [CAPACITY];

  logic [JW-1:0] klen;
  logic          ovf;
  logic [CW-1:0] count;
  logic [CW-1:0] p;
  logic [CW-1:0] i;
  logic [JW-1:0] j;
  logic          del;
  logic          eq_found;
  logic [7:0]    kbuf_q;
  logic [7:0]    wmem_q;
  logic [JW-1:0] lmem_q;

  logic          is_key;
  logic          ch_nz;
  logic          room;
  logic [CW-1:0] src;
  logic [PW-1:0] slot_rd;
  logic [PW-1:0] slot_wr;
  logic [AW-1:0] wrd_addr;
  logic [AW-1:0] wwr_addr;
  logic [CW-1:0] count_next;

  assign is_key = cmd.in_take && (req.req_type == REQ_INSERT || req.req_type == REQ_DELETE);
  assign ch_nz  = (req.key_char != 8'd0);
  assign room   = (32'(klen) < KEY_BYTES);
  assign src    = del ? i + CW'(1) : i - CW'(1);

  assign slot_rd  = (cmd.lrd_src || cmd.wrd_src) ? PW'(src) : PW'(p);
  assign slot_wr  = cmd.wwr_mv ? PW'(i) : PW'(p);
  assign wrd_addr = AW'(slot_rd) * AW'(KEY_BYTES) + AW'(j);
  assign wwr_addr = AW'(slot_wr) * AW'(KEY_BYTES) + AW'(j);

  always_comb begin
    count_next = count;
    if (cmd.cnt_inc) count_next = count + CW'(1);
    if (cmd.cnt_dec) count_next = count - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (is_key && ch_nz && room) kbuf[klen[KIW-1:0]] <= req.key_char;
    if (cmd.krd) kbuf_q <= kbuf[j[KIW-1:0]];
    if (cmd.wrd) wmem_q <= wmem[wrd_addr];
    if (cmd.wwr_mv) wmem[wwr_addr] <= wmem_q;
    if (cmd.wwr_key) wmem[wwr_addr] <= kbuf_q;
    if (cmd.lrd) lmem_q <= lmem[slot_rd];
    if (cmd.lwr_mv) lmem[PW'(i)] <= lmem_q;
    if (cmd.lwr_key) lmem[PW'(p)] <= klen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      klen     <= '0;
      ovf      <= 1'b0;
      count    <= '0;
      p        <= '0;
      i        <= '0;
      j        <= '0;
      del      <= 1'b0;
      eq_found <= 1'b0;
    end else begin
      if (cmd.key_clr) begin
        klen <= '0;
        ovf  <= 1'b0;
      end else if (is_key && ch_nz) begin
        if (room) klen <= klen + JW'(1);
        else ovf <= 1'b1;
      end
      if (is_key) del <= (req.req_type == REQ_DELETE);
      count <= count_next;
      if (cmd.in_take && req.req_type == REQ_READ) begin
        p <= CW'(req.entry_index);
      end else if (cmd.p_clr) begin
        p <= '0;
      end else if (cmd.p_inc) begin
        p <= p + CW'(1);
      end
      if (cmd.p_clr) eq_found <= 1'b0;
      else if (cmd.set_eq) eq_found <= 1'b1;
      if (cmd.i_load_p) i <= p;
      else if (cmd.i_load_cnt) i <= count;
      else if (cmd.i_step) i <= src;
      if (cmd.j_clr) j <= '0;
      else if (cmd.j_inc) j <= j + JW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.status      <= cmd.out_code;
      rsp.out_char    <= cmd.out_byte ? wmem_q : 8'd0;
      rsp.out_last    <= cmd.out_byte ? (32'(j) + 1 == 32'(lmem_q)) : 1'b1;
      rsp.entry_count <= 5'(count_next);
    end
  end

  always_comb begin
    sts.req          = req.req_type;
    sts.last         = req.key_last;
    sts.ovf_now      = ovf || (ch_nz && !room);
    sts.full         = (32'(count) >= CAPACITY);
    sts.idx_bad      = (32'(req.entry_index) >= 32'(count));
    sts.j_lt_n       = (j < klen) && (j < lmem_q);
    sts.key_eq_w     = (klen == lmem_q);
    sts.key_lt_w     = (klen < lmem_q);
    sts.byte_ne      = (kbuf_q != wmem_q);
    sts.key_byte_lt  = (kbuf_q < wmem_q);
    sts.p_lt_cnt     = (p < count);
    sts.i_gt_p       = (i > p);
    sts.i_nxt_lt_cnt = (32'(i) + 1 < 32'(count));
    sts.j_lt_wl      = (j < lmem_q);
    sts.j_lt_klen    = (j < klen);
    sts.j_last       = (32'(j) + 1 == 32'(lmem_q));
    sts.del          = del;
    sts.eq_found     = eq_found;
    sts.out_busy     = rsp_valid;
  end

endmodule

// File: design/sorted_string_set_engine.sv
// ----------------------------------------------------------------------------
// sorted_string_set_engine
// Sorted table of short byte strings with insert, delete and indexed read.
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  req_word_t
//   rsp      out        rsp_valid/rsp_stall  rsp_word_t
//
// A key byte that is not last is taken while the engine stays idle. A read
// fetches the entry length, then reads each byte and waits until its result
// is taken. Insert and delete search the sorted entries byte by byte, move
// each shifted entry; insert then writes the key. All use the word memory.
// Reset is synchronous and clears the counts; memories hold no reset.
// req_stall is high whenever an operation or result is pending.
// ----------------------------------------------------------------------------
module sorted_string_set_engine import sss_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_word_t rsp
);

  cmd_t cmd;
  sts_t sts;

  sss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req_valid),
    .in_stall (req_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sss_dpath #(
    .CAPACITY  (CAPACITY),
    .KEY_BYTES (KEY_BYTES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// File: verif/sorted_string_set_engine_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_string_set_engine_test
// Drives key bytes, operations and indexed reads into the engine with random
// gaps and output stalls, tracks a sorted word table alongside it, and
// compares every result word field by field against the predicted queue.
// ----------------------------------------------------------------------------
module sorted_string_set_engine_test;
  import sss_pkg::*;

  localparam int CAP = 16;
  localparam int KB  = 20;
  localparam longint CYCLE_LIMIT = 2000000;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  req_word_t req;
  logic      rsp_valid;
  logic      rsp_stall;
  rsp_word_t rsp;

  sorted_string_set_engine dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  // table model
  byte unsigned pend_key[$];
  bit           pend_ovf;
  byte unsigned words[CAP][$];
  int           nwords;
  rsp_word_t    rsp_expected[$];
  int           errors;
  longint       cycles;
  bit           stall_on;

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic int key_cmp(input int slot);
    int n;
    n = pend_key.size() < words[slot].size() ? pend_key.size() : words[slot].size();
    for (int i = 0; i < n; i++)
      if (pend_key[i] != words[slot][i]) return pend_key[i] < words[slot][i] ? -1 : 1;
    if (pend_key.size() == words[slot].size()) return 0;
    return pend_key.size() < words[slot].size() ? -1 : 1;
  endfunction

  function automatic void push_rsp(input logic [2:0] st, input logic [7:0] ch,
                                   input logic lst);
    rsp_word_t w;
    w.status = st; w.out_char = ch; w.out_last = lst; w.entry_count = nwords[4:0];
    rsp_expected.push_back(w);
  endfunction

  function automatic void predict_table(input req_word_t w);
    int p;
    logic [2:0] st;
    if (w.req_type == REQ_NONE) return;
    if (w.req_type == REQ_READ) begin
      if (w.entry_index >= nwords) push_rsp(ST_BAD_INDEX, 8'd0, 1'b1);
      else if (words[w.entry_index].size() == 0) push_rsp(ST_BYTE, 8'd0, 1'b1);
      else
        for (int i = 0; i < words[w.entry_index].size(); i++)
          push_rsp(ST_BYTE, words[w.entry_index][i],
                   i == words[w.entry_index].size() - 1);
      return;
    end
    if (w.key_char != 0) begin
      if (pend_key.size() < KB) pend_key.push_back(w.key_char);
      else pend_ovf = 1'b1;
    end
    if (!w.key_last) return;
    p = 0;
    while (p < nwords && key_cmp(p) > 0) p++;
    if (pend_ovf) st = ST_TOO_LONG;
    else if (w.req_type == REQ_INSERT) begin
      if (nwords >= CAP) st = ST_FULL;
      else begin
        for (int i = nwords; i > p; i--) words[i] = words[i-1];
        words[p] = pend_key;
        nwords++;
        st = ST_INSERTED;
      end
    end else begin
      if (p >= nwords || key_cmp(p) != 0) st = ST_NOT_FOUND;
      else begin
        for (int i = p; i + 1 < nwords; i++) words[i] = words[i+1];
        nwords--;
        st = ST_DELETED;
      end
    end
    pend_key.delete();
    pend_ovf = 1'b0;
    push_rsp(st, 8'd0, 1'b1);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // check results and toggle the stall
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp_expected.size() == 0) report("result with none expected");
      else begin
        rsp_word_t e;
        e = rsp_expected.pop_front();
        if (rsp.status !== e.status) report("status");
        if (rsp.out_char !== e.out_char) report("out_char");
        if (rsp.out_last !== e.out_last) report("out_last");
        if (rsp.entry_count !== e.entry_count) report("entry_count");
      end
    end
  end

  initial begin
    int g;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_on) begin
        g = gap_len();
        rsp_stall = g > 0;
        repeat (g > 0 ? g - 1 : 0) @(negedge clk);
      end else rsp_stall = 1'b0;
    end
  end

  task automatic send_word(input logic [1:0] rt, input logic [7:0] ch,
                           input logic lst, input logic [3:0] idx);
    int g;
    g = gap_len();
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    req.req_type <= rt; req.key_char <= ch; req.key_last <= lst;
    req.entry_index <= idx;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_table(req);
    @(negedge clk);
  endtask

  task automatic send_key(input logic [1:0] op, input byte unsigned k[$]);
    for (int i = 0; i < k.size(); i++)
      send_word(op, k[i], i == k.size() - 1, 4'($urandom));
    if (k.size() == 0) send_word(op, 8'd0, 1'b1, 4'd0);
  endtask

  function automatic void rand_key(output byte unsigned k[$], input int maxlen);
    int n;
    n = $urandom_range(0, maxlen);
    k.delete();
    for (int i = 0; i < n; i++) k.push_back(8'($urandom_range(0, 3) == 0 ?
                                       $urandom : $urandom_range(97, 100)));
  endfunction

  task automatic test_directed();
    byte unsigned k[$];
    send_key(REQ_INSERT, '{8'hff});
    send_key(REQ_INSERT, '{8'h01, 8'h00, 8'h80});
    send_key(REQ_INSERT, '{});
    send_key(REQ_INSERT, '{8'h01, 8'h80});
    send_word(REQ_READ, 8'd0, 1'b0, 4'd0);
    send_word(REQ_READ, 8'd0, 1'b0, 4'd2);
    send_word(REQ_READ, 8'hff, 1'b1, 4'd15);
    send_word(REQ_NONE, 8'h55, 1'b1, 4'd1);
    send_word(REQ_INSERT, 8'h41, 1'b0, 4'd0);
    send_word(REQ_READ, 8'd0, 1'b0, 4'd3);
    send_word(REQ_DELETE, 8'hff, 1'b1, 4'd0);
    send_key(REQ_DELETE, '{8'h7f});
    k.delete();
    for (int i = 0; i < KB + 2; i++) k.push_back(8'(8'h30 + i));
    send_key(REQ_INSERT, k);
    k.delete();
    for (int i = 0; i < KB; i++) k.push_back(8'(8'h61 + i));
    k.push_back(8'h00);
    send_key(REQ_INSERT, k);
    send_word(REQ_READ, 8'd0, 1'b0, 4'd3);
  endtask

  task automatic test_fill_table();
    byte unsigned k[$];
    while (nwords < CAP) begin
      rand_key(k, 4);
      send_key(REQ_INSERT, k);
    end
    send_key(REQ_INSERT, '{8'h61});
    for (int i = 0; i < CAP; i++) send_word(REQ_READ, 8'd0, 1'b0, 4'(i));
  endtask

  task automatic test_random();
    byte unsigned k[$];
    int r;
    for (int n = 0; n < 16; ) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        send_word(REQ_READ, 8'($urandom), 1'($urandom), 4'($urandom));
        n++;
      end else if (r < 30) send_word(REQ_NONE, 8'($urandom), 1'($urandom), 4'($urandom));
      else if (r < 35) begin
        rand_key(k, KB + 4);
        send_key(REQ_INSERT, k);
        n += k.size() + 1;
      end else begin
        rand_key(k, 3);
        if (r < 60 && nwords > 0) begin
          r = $urandom_range(0, nwords - 1);
          k = words[r];
        end
        send_key(r[0] ? REQ_DELETE : REQ_INSERT, k);
        n += k.size() + 1;
      end
      if ($urandom_range(0, 9) == 0) stall_on = ~stall_on;
    end
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    errors = 0;
    cycles = 0;
    nwords = 0;
    pend_ovf = 1'b0;
    stall_on = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_fill_table();
    test_random();
    req_valid <= 1'b0;
    while (rsp_expected.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

// File: files.f
design/sss_pkg.sv
design/sss_ctrl.sv
design/sss_dpath.sv
design/sorted_string_set_engine.sv
verif/sorted_string_set_engine_test.sv
